// ----- sv/bda_pkg.sv -----
// Shared types and constants for the binary to decimal ASCII converter.
package bda_pkg;

  localparam int VALUE_WIDTH  = 32;
  localparam int DIGITS       = 10;
  localparam int BCD_WIDTH    = DIGITS * 4;
  localparam int STEP_WIDTH   = $clog2(VALUE_WIDTH);
  localparam int LEN_WIDTH    = 4;
  localparam int CHAR_WIDTH   = 8;
  localparam int CFG_WIDTH    = 8;

  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [CFG_WIDTH-1:0]  BUFFER_SIZE_RESET = 8'd12;

  // Status of the shift-and-add-3 unit.
  typedef struct packed {
    logic busy;
    logic done;
  } dabble_status_t;

  // Command from the top level to the character emitter.
  typedef struct packed {
    logic load;
    logic neg;
  } emit_cmd_t;

endpackage

// ----- sv/bda_dabble.sv -----
// Iterative shift-and-add-3 unit turning a 32-bit magnitude into ten BCD digits.
module bda_dabble (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bda_pkg::VALUE_WIDTH-1:0] mag,
  output logic [bda_pkg::BCD_WIDTH-1:0]   bcd,
  output bda_pkg::dabble_status_t       status
);
  import bda_pkg::*;

  localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(VALUE_WIDTH - 1);

  logic [VALUE_WIDTH-1:0] bin;
  logic [VALUE_WIDTH-1:0] bin_next;
  logic [BCD_WIDTH-1:0]   bcd_adj;
  logic [BCD_WIDTH-1:0]   bcd_next;
  logic [STEP_WIDTH-1:0]  step;
  logic                   running;
  logic                   done;

  // Add three to every digit of five or more, then shift one bit in.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
    {bcd_next, bin_next} = {bcd_adj[BCD_WIDTH-2:0], bin, 1'b0};
  end

  // Step counter and control.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_WIDTH'(1);
        if (step == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (start) begin
      bin <= mag;
      bcd <= '0;
    end else if (running) begin
      bin <= bin_next;
      bcd <= bcd_next;
    end
  end

  assign status.busy = running;
  assign status.done = done;

endmodule

// ----- sv/bda_emit.sv -----
// Character emitter: checks the buffer size and sends the text one word at a time.
module bda_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  bda_pkg::emit_cmd_t             cmd,
  input  logic [bda_pkg::BCD_WIDTH-1:0]  bcd_in,
  input  logic [bda_pkg::CFG_WIDTH-1:0]  buffer_size,
  output logic                           active,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bda_pkg::CHAR_WIDTH-1:0] character,
  output logic                           is_last,
  output logic [bda_pkg::LEN_WIDTH-1:0]  text_length,
  output logic                           too_small
);
  import bda_pkg::*;

  logic [BCD_WIDTH-1:0]  bcd;
  logic [LEN_WIDTH-1:0]  len;
  logic [LEN_WIDTH-1:0]  idx;
  logic                  neg;
  logic                  err;
  logic [LEN_WIDTH-1:0]  digit_count;
  logic [LEN_WIDTH-1:0]  len_load;
  logic                  err_load;
  logic [LEN_WIDTH-1:0]  digit_pos;
  logic [BCD_WIDTH-1:0]  bcd_shift;
  logic [CHAR_WIDTH-1:0] char_cur;
  logic                  last_cur;
  logic                  advance;

  // Count significant digits; zero still has one.
  always_comb begin
    digit_count = LEN_WIDTH'(1);
    for (int i = 1; i < DIGITS; i++) begin
      if (bcd_in[4*i +: 4] != 4'd0) begin
        digit_count = LEN_WIDTH'(i + 1);
      end
    end
    len_load = digit_count + LEN_WIDTH'(cmd.neg);
    err_load = (buffer_size == '0) || (CFG_WIDTH'(len_load) >= buffer_size);
  end

  // Select the character for the current position.
  always_comb begin
    digit_pos = len - LEN_WIDTH'(1) - idx;
    bcd_shift = bcd >> {digit_pos, 2'b00};
    last_cur  = (idx == len - LEN_WIDTH'(1));
    if (neg && (idx == '0)) begin
      char_cur = ASCII_MINUS;
    end else begin
      char_cur = ASCII_ZERO + {4'b0000, bcd_shift[3:0]};
    end
  end

  assign advance = active && (!out_valid || !out_stall);

  // Sequencer over the characters of one word.
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        active <= 1'b1;
      end else if (advance && (err || last_cur)) begin
        active <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item payload and position.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bcd <= bcd_in;
      neg <= cmd.neg;
      len <= len_load;
      err <= err_load;
      idx <= '0;
    end else if (advance) begin
      idx <= idx + LEN_WIDTH'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (err) begin
        character   <= '0;
        is_last     <= 1'b1;
        text_length <= '0;
        too_small   <= 1'b1;
      end else begin
        character   <= char_cur;
        is_last     <= last_cur;
        text_length <= len;
        too_small   <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/binary_to_decimal_ascii_top.sv -----
// Top level of the binary to decimal ASCII converter.
//
// Input channel: value_bits and is_signed, taken when in_valid is high and
// in_stall is low. in_stall stays high from acceptance until the state register
// returns to idle, after the last character of that word has been loaded into the output register.
// Output channel: one word per character, most significant first, each with
// character, is_last, text_length and too_small; a word moves when out_valid
// is high and out_stall is low. A text that does not fit buffer_size gives
// a single error word instead.
// Flow: the shift-and-add-3 unit runs its 32-step conversion loop, then its
// done flag loads the emitter, which loads the characters into the output
// register in order. A new value is taken only once the previous word has
// finished emitting. While out_stall is high the output word holds and the
// emitter waits.
// The user must write buffer_size through cfg_we and cfg_data only while the block is idle;
// the block does not enforce it. Reset clears the control state and sets buffer_size to twelve.
module binary_to_decimal_ascii_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bda_pkg::CFG_WIDTH-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bda_pkg::VALUE_WIDTH-1:0] value_bits,
  input  logic                           is_signed,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bda_pkg::CHAR_WIDTH-1:0] character,
  output logic                           is_last,
  output logic [bda_pkg::LEN_WIDTH-1:0]  text_length,
  output logic                           too_small
);
  import bda_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_CONVERT = 2'd1;
  localparam logic [1:0] ST_EMIT    = 2'd2;

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [CFG_WIDTH-1:0]   buffer_size;
  logic                   neg;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic                   accept;
  logic [BCD_WIDTH-1:0]   bcd;
  dabble_status_t         dab_status;
  emit_cmd_t              cmd;
  logic                   emit_active;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Sign and magnitude of the incoming value.
  assign neg_in = is_signed && value_bits[VALUE_WIDTH-1];
  assign mag_in = neg_in ? (~value_bits + VALUE_WIDTH'(1)) : value_bits;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUFFER_SIZE_RESET;
    end else if (cfg_we) begin
      buffer_size <= cfg_data;
    end
  end

  // Sign flag kept for the emitter.
  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= neg_in;
    end
  end

  // Sequencer state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (dab_status.done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!emit_active) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd.load = (state == ST_CONVERT) && dab_status.done;
  assign cmd.neg  = neg;

  bda_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .mag    (mag_in),
    .bcd    (bcd),
    .status (dab_status)
  );

  bda_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .bcd_in      (bcd),
    .buffer_size (buffer_size),
    .active      (emit_active),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .character   (character),
    .is_last     (is_last),
    .text_length (text_length),
    .too_small   (too_small)
  );

  // An error word carries nothing but the error mark.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && too_small |-> is_last && (text_length == '0) && (character == '0))
    else $error("error word has unexpected fields");

  // A normal word always fits the configured buffer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !too_small |-> (text_length != '0) &&
                                (CFG_WIDTH'(text_length) < buffer_size))
    else $error("text length does not fit the buffer");

  // No new input is taken while the conversion unit is running.
  assert property (@(posedge clk) disable iff (rst)
    dab_status.busy |-> in_stall)
    else $error("input accepted during conversion");

  // Acceptance starts the conversion unit on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> dab_status.busy && (state == ST_CONVERT))
    else $error("conversion did not start");

endmodule
